// File: sv/dtyuv_pkg.sv
// Shared types, delta table and helpers for the delta-table YUV 4:1:1 word decoder.
package dtyuv_pkg;

  localparam int unsigned ValW   = 7;
  localparam int unsigned CodeW  = 5;
  localparam int unsigned WordW  = 32;
  localparam int unsigned SampW  = 8;
  localparam int unsigned NumSamp = 6;
  localparam int unsigned OutW   = SampW * NumSamp;

  // Bit positions of the six codes in the half-swapped word
  localparam int unsigned PosY0 = 0;
  localparam int unsigned PosY1 = 5;
  localparam int unsigned PosY2 = 10;
  localparam int unsigned PosY3 = 16;
  localparam int unsigned PosU  = 21;
  localparam int unsigned PosV  = 26;

  typedef logic [ValW-1:0]  val_t;
  typedef logic [CodeW-1:0] code_t;

  // Running values carried from one word to the next
  typedef struct packed {
    val_t luma;
    val_t u;
    val_t v;
  } state_t;

  // Decoded values of one word, before scaling to samples
  typedef struct packed {
    val_t y0;
    val_t y1;
    val_t y2;
    val_t y3;
    val_t u;
    val_t v;
  } samples_t;

  // Nonlinear delta table, indexed by code
  localparam val_t DeltaTab [32] = '{
    7'd0,   7'd1,   7'd2,   7'd3,   7'd4,   7'd5,   7'd6,   7'd7,
    7'd8,   7'd9,   7'd12,  7'd15,  7'd20,  7'd25,  7'd34,  7'd46,
    7'd64,  7'd82,  7'd94,  7'd103, 7'd108, 7'd113, 7'd116, 7'd119,
    7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125, 7'd126, 7'd127
  };

  // Add a table delta, wrapping modulo 128
  function automatic val_t add_delta(input val_t base, input code_t code);
    add_delta = base + DeltaTab[code];
  endfunction

  // Absolute load: code times 4, modulo 128
  function automatic val_t load_abs(input code_t code);
    load_abs = {code, 2'b00};
  endfunction

  // Scale a value to an 8-bit sample
  function automatic logic [SampW-1:0] to_sample(input val_t value);
    to_sample = {value, 1'b0};
  endfunction

endpackage

// File: sv/dtyuv_decode.sv
// Combinational decode of one word: half swap, code extraction and delta chain.
module dtyuv_decode (
  input  logic [dtyuv_pkg::WordW-1:0] word,
  input  logic                        row_start,
  input  dtyuv_pkg::state_t           state,
  output dtyuv_pkg::state_t           state_next,
  output dtyuv_pkg::samples_t         samples
);

  logic [dtyuv_pkg::WordW-1:0] swapped;
  dtyuv_pkg::code_t c_y0, c_y1, c_y2, c_y3, c_u, c_v;
  dtyuv_pkg::val_t  y0, y1, y2, y3, u, v;

  // Exchange the 16-bit halves, then slice out the six codes
  assign swapped = {word[15:0], word[31:16]};
  assign c_y0 = swapped[dtyuv_pkg::PosY0 +: dtyuv_pkg::CodeW];
  assign c_y1 = swapped[dtyuv_pkg::PosY1 +: dtyuv_pkg::CodeW];
  assign c_y2 = swapped[dtyuv_pkg::PosY2 +: dtyuv_pkg::CodeW];
  assign c_y3 = swapped[dtyuv_pkg::PosY3 +: dtyuv_pkg::CodeW];
  assign c_u  = swapped[dtyuv_pkg::PosU  +: dtyuv_pkg::CodeW];
  assign c_v  = swapped[dtyuv_pkg::PosV  +: dtyuv_pkg::CodeW];

  // Load absolute values on a row start, otherwise accumulate deltas
  always_comb begin
    if (row_start) begin
      y0 = dtyuv_pkg::load_abs(c_y0);
      u  = dtyuv_pkg::load_abs(c_u);
      v  = dtyuv_pkg::load_abs(c_v);
    end else begin
      y0 = dtyuv_pkg::add_delta(state.luma, c_y0);
      u  = dtyuv_pkg::add_delta(state.u, c_u);
      v  = dtyuv_pkg::add_delta(state.v, c_v);
    end
  end

  // Chain the later luma values
  assign y1 = dtyuv_pkg::add_delta(y0, c_y1);
  assign y2 = dtyuv_pkg::add_delta(y1, c_y2);
  assign y3 = dtyuv_pkg::add_delta(y2, c_y3);

  assign state_next.luma = y3;
  assign state_next.u    = u;
  assign state_next.v    = v;

  assign samples.y0 = y0;
  assign samples.y1 = y1;
  assign samples.y2 = y2;
  assign samples.y3 = y3;
  assign samples.u  = u;
  assign samples.v  = v;

endmodule

// File: sv/delta_table_yuv411_word_decoder.sv
// Top level of the delta-table YUV 4:1:1 word decoder: input register, decode, result register.
// An accepted request passes through the input register and then the result register to the master side.
// Throughput: one word per cycle while the master side does not stall; the delta chain between
//   input and result register sets the cycle time.
// Reset (rst, synchronous, active high) empties both stages and clears the running
//   luma and chroma values to zero.
module delta_table_yuv411_word_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [dtyuv_pkg::WordW-1:0]  s_axis_tdata,   // [31:0] packed_word
  input  logic [0:0]                   s_axis_tuser,   // [0] row_start
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [dtyuv_pkg::OutW-1:0]   m_axis_tdata    // luma0, luma1, luma2, luma3,
                                                       // chroma_u, chroma_v (8 bits each)
);

  logic                        in_valid;
  logic [dtyuv_pkg::WordW-1:0] in_word;
  logic                        in_start;
  logic                        out_valid;
  logic [dtyuv_pkg::OutW-1:0]  out_data;
  dtyuv_pkg::state_t           state;
  dtyuv_pkg::state_t           state_next;
  dtyuv_pkg::samples_t         samples;
  logic                        advance;

  // Move the held request into the result register when that register frees up
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_word  <= s_axis_tdata;
      in_start <= s_axis_tuser[0];
    end
  end

  dtyuv_decode u_decode (
    .word       (in_word),
    .row_start  (in_start),
    .state      (state),
    .state_next (state_next),
    .samples    (samples)
  );

  // Update running values as each request leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register: hold while stalled, load on advance
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_data <= {dtyuv_pkg::to_sample(samples.v),
                   dtyuv_pkg::to_sample(samples.u),
                   dtyuv_pkg::to_sample(samples.y3),
                   dtyuv_pkg::to_sample(samples.y2),
                   dtyuv_pkg::to_sample(samples.y1),
                   dtyuv_pkg::to_sample(samples.y0)};
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
